@@ rtl/subband_dedisperser_core_defines.svh @@
// Assertion macros for the subband dedisperser RTL.
`ifndef SUBBAND_DEDISPERSER_CORE_DEFINES_SVH
`define SUBBAND_DEDISPERSER_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sbd_pkg.sv @@
// Constants, types and state codes of the subband dedisperser.
package sbd_pkg;

    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_SUBBANDS = 16;
    localparam int DELAY_ROWS   = 1024;

    localparam int CH_W   = 10;   // channel field
    localparam int DLY_W  = 10;   // delay field and max_delay register
    localparam int SB_W   = 4;    // subband field
    localparam int SMP_W  = 16;   // sample field
    localparam int SUM_W  = 26;   // accumulator and sum field
    localparam int TIME_W = 32;   // output time field
    localparam int CNT_W  = 11;   // channels_in_use register
    localparam int NSB_W  = 5;    // subbands_in_use register
    localparam int CFG_W  = 11;   // widest register
    localparam int CFG_IW = 2;    // register index

    localparam int ROW_W     = $clog2(DELAY_ROWS);
    localparam int FILL_W    = $clog2(DELAY_ROWS + 1);
    localparam int ACC_AW    = ROW_W + SB_W;
    localparam int ACC_DEPTH = 1 << ACC_AW;
    localparam int CLR_LEN   = (ACC_DEPTH > MAX_CHANNELS) ? ACC_DEPTH : MAX_CHANNELS;
    localparam int CLR_W     = $clog2(CLR_LEN);

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CHANNELS  = 2'd0,
        CFG_SUBBANDS  = 2'd1,
        CFG_MAX_DELAY = 2'd2
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_ADD   = 6'b001000,
        S_ERD   = 6'b010000,
        S_EOUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [DLY_W-1:0] dly;
        logic [SB_W-1:0]  sb;
    } t_tbl_entry;

    // Request to the accumulator store.
    typedef struct packed {
        logic                     rd;        // read rd_addr
        logic                     clr_on_rd; // zero rd_addr as it is read
        logic                     zero;      // zero rd_addr, no read
        logic [ACC_AW-1:0]        rd_addr;
        logic                     add;       // add smp to the last read word
        logic [ACC_AW-1:0]        add_addr;
        logic signed [SMP_W-1:0]  smp;
    } t_acc_req;

endpackage

@@ rtl/sbd_in_if.sv @@
// Input channel of the subband dedisperser: table loads and samples.
interface sbd_in_if;
    import sbd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [CH_W-1:0]         channel;
    logic [DLY_W-1:0]        delay;
    logic [SB_W-1:0]         subband;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, kind, channel, delay, subband, sample, input ready);
    modport sink   (input valid, kind, channel, delay, subband, sample, output ready);
endinterface

@@ rtl/sbd_out_if.sv @@
// Output channel of the subband dedisperser: one subband sum per transaction.
interface sbd_out_if;
    import sbd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       out_time;
    logic [SB_W-1:0]         out_subband;
    logic signed [SUM_W-1:0] sum;
    logic                    last;

    modport source (output valid, out_time, out_subband, sum, last, input ready);
    modport sink   (input valid, out_time, out_subband, sum, last, output ready);
endinterface

@@ rtl/sbd_accum.sv @@
// Accumulator store: registered read, saturating add back, clear on read.
module sbd_accum (
    input  logic                          i_clk,
    input  sbd_pkg::t_acc_req             i_req,
    output logic signed [sbd_pkg::SUM_W-1:0] o_rdata
);
    import sbd_pkg::*;

    localparam logic signed [SUM_W:0] SAT_MAX = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0] SAT_MIN = -(SUM_W+1)'(1 << (SUM_W-1));

    logic signed [SUM_W-1:0] r_acc_mem [ACC_DEPTH];
    logic signed [SUM_W-1:0] r_rdata;

    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    we;
    logic [ACC_AW-1:0]       wa;
    logic signed [SUM_W-1:0] wd;

    // Widen by one bit so the add cannot wrap, then clamp.
    always_comb begin
        sum_wide = {r_rdata[SUM_W-1], r_rdata}
                 + {{(SUM_W+1-SMP_W){i_req.smp[SMP_W-1]}}, i_req.smp};
        if (sum_wide > SAT_MAX) begin
            sum_sat = SAT_MAX[SUM_W-1:0];
        end else if (sum_wide < SAT_MIN) begin
            sum_sat = SAT_MIN[SUM_W-1:0];
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign we = i_req.add || i_req.zero || (i_req.rd && i_req.clr_on_rd);
    assign wa = i_req.add ? i_req.add_addr : i_req.rd_addr;
    assign wd = i_req.add ? sum_sat : '0;

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_acc_mem[i_req.rd_addr];
        end
        if (we) begin
            r_acc_mem[wa] <= wd;
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/subband_dedisperser_core.sv @@
// Top level of the streaming subband dedisperser.
//
// Input channel i_in: a kind 0 transaction loads the delay (clamped to
// max_delay) and subband of one channel; a kind 1 transaction carries the
// sample of the current channel, channels in order, then the next time step.
// Output channel o_out: after the last channel of time T, once T has reached
// max_delay, one transaction per subband in use carries the sum for output
// time T - max_delay; last marks the final subband of that time.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data write one register per
// cycle; write only while the block is idle.
// Flow: a load only writes the table; a sample passes through table read,
// accumulator read and write back through the single-port table and
// accumulator memories before the next input is taken. A time step that
// emits adds, per subband in use, a read and clear of the row, then a load
// of the output register. The first sum of a time step is read once the
// output register has room, after the lookup and add of its last sample.
// Reset: i_rst_n is synchronous. After it the block sweeps both memories to
// zero, one entry a cycle over 16384 entries, and takes no input until done;
// configuration writes are taken throughout.
// Stall: an emission waits for its output register; while a burst is held
// no input transaction is taken. A single pending result does not hold input.
`include "subband_dedisperser_core_defines.svh"

module subband_dedisperser_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sbd_in_if.sink                       i_in,
    sbd_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [sbd_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [sbd_pkg::CFG_W-1:0]    i_cfg_data
);
    import sbd_pkg::*;

    // Control state
    t_state            r_state, n_state;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [TIME_W-1:0] r_time, n_time;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SB_W-1:0]   r_e_idx, n_e_idx;
    logic              r_out_valid, n_out_valid;

    // Configuration registers
    logic [CNT_W-1:0]  r_chans;
    logic [NSB_W-1:0]  r_subs;
    logic [DLY_W-1:0]  r_maxd;

    // Payload registers
    logic signed [SMP_W-1:0] r_smp;
    logic                    r_last;
    logic                    r_do_add;
    logic [ACC_AW-1:0]       r_add_addr;
    logic [TIME_W-1:0]       r_out_time;
    logic [SB_W-1:0]         r_out_sb;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    // Channel table
    t_tbl_entry        r_tbl_mem [MAX_CHANNELS];
    t_tbl_entry        r_tbl_rd;
    logic              tbl_we, tbl_re;
    logic [CH_W-1:0]   tbl_wa;
    t_tbl_entry        tbl_wd;

    // Effective register values and datapath terms
    logic [DLY_W-1:0]  md;
    logic [CNT_W-1:0]  nch;
    logic [NSB_W-1:0]  nsb;
    logic [DLY_W-1:0]  lk_d;
    logic              lk_add;
    logic [ROW_W-1:0]  lk_row;
    logic [ROW_W-1:0]  em_row;
    logic              em_last;
    logic              in_acc;
    logic              out_free;
    logic              step_last;

    t_acc_req                acc_req;
    logic signed [SUM_W-1:0] acc_rdata;

    // Row of time (row - d), modulo the row count.
    function automatic logic [ROW_W-1:0] row_back(input logic [ROW_W-1:0] row,
                                                  input logic [DLY_W-1:0] d);
        logic [ROW_W:0] w;
        w = {1'b0, row} + (ROW_W+1)'(DELAY_ROWS) - (ROW_W+1)'(d);
        if (w >= (ROW_W+1)'(DELAY_ROWS)) begin
            w = w - (ROW_W+1)'(DELAY_ROWS);
        end
        return w[ROW_W-1:0];
    endfunction

    always_comb begin
        if (int'(r_maxd) > DELAY_ROWS - 1) begin
            md = DLY_W'(DELAY_ROWS - 1);
        end else begin
            md = r_maxd;
        end
        if (r_chans == '0) begin
            nch = CNT_W'(1);
        end else if (int'(r_chans) > MAX_CHANNELS) begin
            nch = CNT_W'(MAX_CHANNELS);
        end else begin
            nch = r_chans;
        end
        if (r_subs == '0) begin
            nsb = NSB_W'(1);
        end else if (int'(r_subs) > MAX_SUBBANDS) begin
            nsb = NSB_W'(MAX_SUBBANDS);
        end else begin
            nsb = r_subs;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign step_last  = (CNT_W'(r_ch) + CNT_W'(1)) >= nch;

    // Lookup: clamp the stored delay to the current max_delay; drop unused
    // subbands and contributions that would land before time zero.
    assign lk_d   = (r_tbl_rd.dly > md) ? md : r_tbl_rd.dly;
    assign lk_add = (NSB_W'(r_tbl_rd.sb) < nsb) && (FILL_W'(lk_d) <= r_fill);
    assign lk_row = row_back(r_row, lk_d);

    assign em_row  = row_back(r_row, md);
    assign em_last = (NSB_W'(r_e_idx) + NSB_W'(1)) == nsb;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ch        = r_ch;
        n_time      = r_time;
        n_fill      = r_fill;
        n_row       = r_row;
        n_e_idx     = r_e_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        acc_req     = '0;
        acc_req.smp = r_smp;
        tbl_we      = 1'b0;
        tbl_re      = 1'b0;
        tbl_wa      = i_in.channel;
        tbl_wd.dly  = (i_in.delay < md) ? i_in.delay : md;
        tbl_wd.sb   = i_in.subband;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep both memories to zero, one entry a cycle.
                acc_req.zero    = int'(r_clr) < ACC_DEPTH;
                acc_req.rd_addr = ACC_AW'(r_clr);
                if (int'(r_clr) < MAX_CHANNELS) begin
                    tbl_we = 1'b1;
                    tbl_wa = CH_W'(r_clr);
                    tbl_wd = '0;
                end
                if (r_clr == CLR_W'(CLR_LEN - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + CLR_W'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == KIND_LOAD) begin
                        tbl_we = 1'b1;
                    end else begin
                        tbl_re  = 1'b1;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                acc_req.rd      = 1'b1;
                acc_req.rd_addr = {lk_row, r_tbl_rd.sb};
                n_state         = S_ADD;
            end
            S_ADD: begin
                acc_req.add      = r_do_add;
                acc_req.add_addr = r_add_addr;
                if (!r_last) begin
                    n_ch    = r_ch + CH_W'(1);
                    n_state = S_IDLE;
                end else begin
                    n_ch = '0;
                    if (r_fill >= FILL_W'(md)) begin
                        n_e_idx = '0;
                        n_state = S_ERD;
                    end else begin
                        n_time  = r_time + TIME_W'(1);
                        n_row   = (r_row == ROW_W'(DELAY_ROWS - 1)) ? '0 : r_row + ROW_W'(1);
                        n_fill  = (int'(r_fill) < DELAY_ROWS) ? r_fill + FILL_W'(1) : r_fill;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERD: begin
                // Read and clear one sum once the output register has room.
                if (out_free) begin
                    acc_req.rd        = 1'b1;
                    acc_req.clr_on_rd = 1'b1;
                    acc_req.rd_addr   = {em_row, r_e_idx};
                    n_state           = S_EOUT;
                end
            end
            S_EOUT: begin
                n_out_valid = 1'b1;
                if (em_last) begin
                    n_time  = r_time + TIME_W'(1);
                    n_row   = (r_row == ROW_W'(DELAY_ROWS - 1)) ? '0 : r_row + ROW_W'(1);
                    n_fill  = (int'(r_fill) < DELAY_ROWS) ? r_fill + FILL_W'(1) : r_fill;
                    n_state = S_IDLE;
                end else begin
                    n_e_idx = r_e_idx + SB_W'(1);
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ch        <= '0;
            r_time      <= '0;
            r_fill      <= '0;
            r_row       <= '0;
            r_e_idx     <= '0;
            r_out_valid <= 1'b0;
            r_chans     <= CNT_W'(MAX_CHANNELS);
            r_subs      <= NSB_W'(1);
            r_maxd      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ch        <= n_ch;
            r_time      <= n_time;
            r_fill      <= n_fill;
            r_row       <= n_row;
            r_e_idx     <= n_e_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHANNELS:  r_chans <= i_cfg_data[CNT_W-1:0];
                    CFG_SUBBANDS:  r_subs  <= i_cfg_data[NSB_W-1:0];
                    CFG_MAX_DELAY: r_maxd  <= i_cfg_data[DLY_W-1:0];
                    default: begin
                        // Index beyond the register list: drop the write.
                    end
                endcase
            end
        end
    end

    // Hold the sample and its lookup results between the pipeline steps.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_smp  <= i_in.sample;
            r_last <= step_last;
        end
        if (r_state == S_LOOK) begin
            r_do_add   <= lk_add;
            r_add_addr <= {lk_row, r_tbl_rd.sb};
        end
        if (r_state == S_EOUT) begin
            r_out_time <= r_time - TIME_W'(md);
            r_out_sb   <= r_e_idx;
            r_out_sum  <= acc_rdata;
            r_out_last <= em_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (tbl_re) begin
            r_tbl_rd <= r_tbl_mem[r_ch];
        end
    end

    sbd_accum u_accum (
        .i_clk   (i_clk),
        .i_req   (acc_req),
        .o_rdata (acc_rdata)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.out_time    = r_out_time;
    assign o_out.out_subband = r_out_sb;
    assign o_out.sum         = r_out_sum;
    assign o_out.last        = r_out_last;

    `SBD_ASSERT_NOW(a_eout_room, r_state == S_EOUT, !r_out_valid, "output register overwritten")
    `SBD_ASSERT_NOW(a_eout_after_read, r_state == S_EOUT, $past(r_state) == S_ERD, "emit without read")
    `SBD_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_W'(DELAY_ROWS), "fill count overrun")
    `SBD_ASSERT_NEXT(a_sample_look, in_acc && i_in.kind == KIND_SAMPLE, r_state == S_LOOK, "sample not looked up")
    `SBD_ASSERT_NEXT(a_clear_end, r_state == S_CLEAR && r_clr == CLR_W'(CLR_LEN - 1), r_state == S_IDLE, "sweep did not end")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the subband dedisperser core: random and directed streams.
module tb;
    import sbd_pkg::*;

    localparam int     CLK_HALF        = 4;
    localparam int     RESET_CYCLES    = 11;
    localparam int     WATCHDOG_CYCLES = 1_000_000;
    localparam int     IDLE_TAIL       = 16;
    localparam int     END_TAIL        = 40;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     RANDOM_PHASES   = 4;
    localparam int     PHASE_ITEMS     = 25;
    localparam int     CLAMP_SAMPLES   = 8;
    localparam int     LAG_DEPTH       = 8;
    localparam int     LAG_STEPS       = 24;
    localparam longint SUM_TOP         = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_BOTTOM      = -(longint'(1) <<< (SUM_W - 1));
    localparam int     SMP_TOP         = 32767;
    localparam int     SMP_BOTTOM      = -32768;

    // One transaction on the input channel.
    typedef struct {
        logic                    kind;
        logic [CH_W-1:0]         channel;
        logic [DLY_W-1:0]        delay;
        logic [SB_W-1:0]         subband;
        logic signed [SMP_W-1:0] sample;
    } feed_t;

    // One subband sum on the output channel.
    typedef struct packed {
        logic [TIME_W-1:0]       out_time;
        logic [SB_W-1:0]         out_subband;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } sum_rec_t;

    // Ready behaviour of the output side, drawn anew for each span of the sink.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PATTERN,
        SINK_SPARSE
    } sink_mode_t;

    // Tracks the delay table, the accumulator rows and the counters, and keeps the sums
    // that the block owes in the order that it must send them.
    class subband_sum_predictor;
        logic [DLY_W-1:0]  delay_of [MAX_CHANNELS];
        logic [SB_W-1:0]   band_of  [MAX_CHANNELS];
        int                row_sum  [DELAY_ROWS*MAX_SUBBANDS];
        int unsigned       chan_pos;
        bit [TIME_W-1:0]   step_no;
        int unsigned       filled;
        int unsigned       row_at;
        logic [CNT_W-1:0]  n_chan_reg;
        logic [NSB_W-1:0]  n_band_reg;
        logic [DLY_W-1:0]  lag_reg;
        sum_rec_t          expected_sums[$];
        int                errors;
        int                checked;
        int                absorbed;
        int                writes;

        function new();
            foreach (delay_of[i]) begin
                delay_of[i] = '0;
                band_of[i]  = '0;
            end
            foreach (row_sum[i]) row_sum[i] = 0;
            chan_pos   = 0;
            step_no    = '0;
            filled     = 0;
            row_at     = 0;
            n_chan_reg = CNT_W'(MAX_CHANNELS);
            n_band_reg = NSB_W'(1);
            lag_reg    = '0;
            errors     = 0;
            checked    = 0;
            absorbed   = 0;
            writes     = 0;
        endfunction

        function void configure(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_CHANNELS:  n_chan_reg = val[CNT_W-1:0];
                CFG_SUBBANDS:  n_band_reg = val[NSB_W-1:0];
                CFG_MAX_DELAY: lag_reg    = val[DLY_W-1:0];
                default: ;
            endcase
            writes++;
        endfunction

        function void take_input(feed_t it);
            int unsigned lag, nch, nsb, c, d, r, k, s;
            longint      acc;
            sum_rec_t    rec;
            absorbed++;
            lag = (lag_reg < DELAY_ROWS - 1) ? lag_reg : DELAY_ROWS - 1;
            nch = (n_chan_reg == 0) ? 1 :
                  (n_chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : n_chan_reg;
            nsb = (n_band_reg == 0) ? 1 :
                  (n_band_reg > MAX_SUBBANDS) ? MAX_SUBBANDS : n_band_reg;

            if (it.kind == KIND_LOAD) begin
                // Store the delay already clamped to the lag in force now.
                delay_of[it.channel] = (it.delay < lag) ? it.delay : DLY_W'(lag);
                band_of[it.channel]  = it.subband;
                return;
            end

            c = chan_pos;
            d = delay_of[c];
            if (d > lag) d = lag;
            // Drop samples of unused subbands and those whose output time lies before zero.
            if (band_of[c] < nsb && filled >= d) begin
                r   = (row_at + DELAY_ROWS - d) % DELAY_ROWS;
                k   = r * MAX_SUBBANDS + band_of[c];
                acc = longint'(row_sum[k]) + longint'(it.sample);
                if (acc > SUM_TOP) acc = SUM_TOP;
                if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
                row_sum[k] = int'(acc);
            end

            if (c + 1 < nch) begin
                chan_pos = c + 1;
                return;
            end

            // Last channel of the time step: flush the row that has aged by the full lag.
            chan_pos = 0;
            if (filled >= lag) begin
                r = (row_at + DELAY_ROWS - lag) % DELAY_ROWS;
                for (s = 0; s < nsb; s++) begin
                    k               = r * MAX_SUBBANDS + s;
                    rec.out_time    = step_no - lag;
                    rec.out_subband = s[SB_W-1:0];
                    rec.sum         = row_sum[k][SUM_W-1:0];
                    rec.last        = (s + 1 == nsb);
                    expected_sums.push_back(rec);
                    row_sum[k] = 0;
                end
            end
            step_no = step_no + 1;
            row_at  = (row_at + 1) % DELAY_ROWS;
            if (filled < DELAY_ROWS) filled++;
        endfunction

        function void check_sum(sum_rec_t got);
            sum_rec_t want;
            checked++;
            if (expected_sums.size() == 0) begin
                $error("sum with nothing expected: out_time %0d out_subband %0d sum %0d",
                       got.out_time, got.out_subband, $signed(got.sum));
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            if (got.out_time !== want.out_time) begin
                $error("out_time: expected %0d, got %0d", want.out_time, got.out_time);
                errors++;
            end
            if (got.out_subband !== want.out_subband) begin
                $error("out_subband: expected %0d, got %0d", want.out_subband, got.out_subband);
                errors++;
            end
            if (got.sum !== want.sum) begin
                $error("sum: expected %0d, got %0d", $signed(want.sum), $signed(got.sum));
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IW-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               squeeze_armed;
    logic               squeeze_done;
    int                 burst_left;

    subband_sum_predictor sums;

    sbd_in_if  in_bus ();
    sbd_out_if out_bus ();

    subband_dedisperser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, clearing sweep included.
    initial begin
        #(2 * CLK_HALF * WATCHDOG_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // Compare every sum the moment its transaction completes.
    always @(posedge clk) begin : watch_sums
        sum_rec_t seen;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            seen.out_time    = out_bus.out_time;
            seen.out_subband = out_bus.out_subband;
            seen.sum         = out_bus.sum;
            seen.last        = out_bus.last;
            sums.check_sum(seen);
        end
    end

    // Output side: stall on a pattern of its own, and once hold ready low for a long stretch
    // so that the block backs up and stops taking input.
    initial begin : sink_side
        sink_mode_t  mode;
        int          span;
        bit [31:0]   pattern;
        out_bus.ready = 1'b0;
        squeeze_done  = 1'b0;
        @(negedge clk);
        forever begin
            if (squeeze_armed && !squeeze_done) begin
                out_bus.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                squeeze_done = 1'b1;
            end
            mode    = sink_mode_t'($urandom_range(0, 3));
            span    = $urandom_range(8, 40);
            pattern = $urandom;
            for (int i = 0; i < span; i++) begin
                if (squeeze_armed && !squeeze_done) break;
                case (mode)
                    SINK_OPEN:    out_bus.ready = 1'b1;
                    SINK_COIN:    out_bus.ready = ($urandom_range(0, 1) == 1);
                    SINK_PATTERN: out_bus.ready = pattern[i % 32];
                    default:      out_bus.ready = ($urandom_range(0, 3) == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    function automatic feed_t load_item(int unsigned ch, int unsigned dl, int unsigned sb);
        feed_t it;
        it.kind    = KIND_LOAD;
        it.channel = ch[CH_W-1:0];
        it.delay   = dl[DLY_W-1:0];
        it.subband = sb[SB_W-1:0];
        it.sample  = SMP_W'($urandom);   // ignored on a load, toggled anyway
        return it;
    endfunction

    function automatic feed_t sample_item(int value);
        feed_t it;
        it.kind    = KIND_SAMPLE;
        it.channel = CH_W'($urandom);    // ignored on a sample
        it.delay   = DLY_W'($urandom);
        it.subband = SB_W'($urandom);
        it.sample  = value[SMP_W-1:0];
        return it;
    endfunction

    // Lean towards the extremes of the sample range.
    function automatic int rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_TOP;
            1:       return SMP_BOTTOM;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // Offer one transaction; bursts of random length, random gaps between them.
    task automatic push_item(input feed_t it);
        int gap;
        if (burst_left == 0) burst_left = $urandom_range(1, 16);
        in_bus.valid   = 1'b1;
        in_bus.kind    = it.kind;
        in_bus.channel = it.channel;
        in_bus.delay   = it.delay;
        in_bus.subband = it.subband;
        in_bus.sample  = it.sample;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        sums.take_input(it);
        burst_left--;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                in_bus.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_W-1:0];
        @(posedge clk);
        sums.configure(idx, val[CFG_W-1:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Stop offering, wait for every owed sum, then give a sample still in flight time to land.
    task automatic settle(input int tail);
        in_bus.valid = 1'b0;
        burst_left   = 0;
        while (sums.expected_sums.size() != 0) @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    initial begin : stimulus
        int corner_samples [12] = '{SMP_TOP, SMP_BOTTOM, 1, SMP_BOTTOM, SMP_TOP, -1,
                                    21845, -21846, 0, 1000, -1, SMP_TOP};
        int unsigned nch, eff, n;
        sums           = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        squeeze_armed  = 1'b0;
        burst_left     = 0;
        in_bus.valid   = 1'b0;
        in_bus.kind    = KIND_LOAD;
        in_bus.channel = '0;
        in_bus.delay   = '0;
        in_bus.subband = '0;
        in_bus.sample  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. Subbands stay at their reset count of one and channel 0 keeps
        // its reset table entry. Clamp a delay of 1023 to the lag of two, park channel 2 in
        // an unused subband, load the top channel, and drop the early samples whose output
        // time would fall before zero.
        write_reg(CFG_CHANNELS, 3);
        write_reg(CFG_MAX_DELAY, 2);
        push_item(load_item(1, 1023, 0));
        push_item(load_item(2, 1, 15));
        push_item(load_item(MAX_CHANNELS - 1, 682, 10));
        foreach (corner_samples[i]) push_item(sample_item(corner_samples[i]));
        // Leave the channel counter mid step, then shrink the channel count below it: the
        // next sample closes the step. Zero counts act as one, and a lag of zero clamps the
        // stored delays as they are used.
        push_item(sample_item(SMP_TOP));
        push_item(sample_item(SMP_BOTTOM));
        settle(IDLE_TAIL);
        write_reg(CFG_CHANNELS, 0);
        write_reg(CFG_SUBBANDS, 0);
        write_reg(CFG_MAX_DELAY, 0);
        push_item(sample_item(SMP_BOTTOM));
        push_item(sample_item(SMP_TOP));
        push_item(sample_item(-5));

        // An oversized channel count acts as the full count, so a few samples close no step;
        // a small count afterwards makes the next sample the last of its step.
        settle(IDLE_TAIL);
        write_reg(CFG_CHANNELS, 2047);
        repeat (CLAMP_SAMPLES) push_item(sample_item(rand_sample()));
        settle(IDLE_TAIL);
        write_reg(CFG_CHANNELS, 3);
        push_item(sample_item(SMP_BOTTOM));
        push_item(sample_item(rand_sample()));

        // One channel with an oversized subband count: once the history fills, every step
        // emits all sixteen subbands.
        settle(IDLE_TAIL);
        write_reg(CFG_CHANNELS, 1);
        write_reg(CFG_SUBBANDS, 31);
        write_reg(CFG_MAX_DELAY, LAG_DEPTH);
        push_item(load_item(0, 1023, 15));
        for (int i = 0; i < LAG_STEPS; i++) begin
            if (i % 8 == 7)
                push_item(load_item(0, $urandom_range(0, 1023), $urandom_range(0, 15)));
            push_item(sample_item(rand_sample()));
        end

        // Random phases: load a table for the channels in use, then stream samples with the
        // odd stray load mixed in. Hold the output off for a long stretch in the second, with
        // a short lag so that sums back up.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle(IDLE_TAIL);
            nch = (ph == 1) ? 2 : ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            write_reg(CFG_CHANNELS, nch);
            write_reg(CFG_SUBBANDS, $urandom_range(0, 31));
            write_reg(CFG_MAX_DELAY,
                      (ph == 1 || $urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                                             : $urandom_range(0, 1023));
            if (ph == 1) squeeze_armed = 1'b1;
            eff = (nch == 0) ? 1 : nch;
            for (int c = 0; c < eff; c++)
                push_item(load_item(c, $urandom_range(0, 1023), $urandom_range(0, 15)));
            n = eff;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    push_item(load_item($urandom_range(0, MAX_CHANNELS - 1),
                                        $urandom_range(0, 1023), $urandom_range(0, 15)));
                else
                    push_item(sample_item(rand_sample()));
                n++;
            end
        end

        settle(END_TAIL);
        $display("Run: %0d input transactions, %0d sums checked, %0d register writes.",
                 sums.absorbed, sums.checked, sums.writes);
        $display("Covered delay and count clamps, unused subbands, full sixteen-sum bursts "
                 , "and a long output hold-off.");
        if (sums.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
